// File: rtl/stereo_ring_modulator_macros.svh
// Assertion macros shared by the ring modulator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef STEREO_RING_MODULATOR_MACROS_SVH
`define STEREO_RING_MODULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srm: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srm: next-cycle check failed");

`endif

// File: rtl/srm_pkg.sv
// Package for the stereo ring modulator: widths, reset values, register
// indexes, sequencer states and the sine table generator. No dependencies.
package srm_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT = 24;
    localparam int SINE_DEPTH_DEFAULT   = 1024;

    localparam int PHASE_WIDTH     = 32;
    localparam int INC_WIDTH       = 31;
    localparam int GAIN_WIDTH      = 16;
    localparam int SINE_WIDTH      = 16;
    localparam int WET_WIDTH       = 32;   // crossfade gain, Q2.30
    localparam int ACC_WIDTH       = 33;   // serial multiplier upper half
    localparam int ROUND_SHIFT     = 30;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 31;

    localparam logic [INC_WIDTH-1:0]  PHASE_INC_RESET = 31'd894785;
    localparam logic [GAIN_WIDTH-1:0] UNITY           = 16'd32768;
    localparam logic [GAIN_WIDTH-1:0] DEPTH_RESET     = 16'd32768;
    localparam logic [GAIN_WIDTH-1:0] MIX_RESET       = 16'd0;

    localparam logic signed [SINE_WIDTH-1:0] SINE_MOST_NEG = 16'sh8000;
    // half an output LSB at the 2^30 scale, preloaded into the accumulator
    localparam logic signed [ACC_WIDTH-1:0]  ACC_ROUND     = 33'sd536870912;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PHASE_INC = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEPTH     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIX       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DEPTH,
        ST_WET,
        ST_MUL,
        ST_DONE
    } srm_state_t;

    localparam longint Q30 = longint'(1) <<< 30;
    localparam longint POLY_C [5] = '{
        64'sd1686629713, -64'sd693598669, 64'sd85569306, -64'sd5026995, 64'sd172272
    };

    // Quarter-wave odd polynomial in Q2.30, rounded to Q1.15.
    // Used at elaboration only to build the sine ROM contents.
    function automatic logic signed [SINE_WIDTH-1:0] sine_of_phase(
        input logic [PHASE_WIDTH-1:0] p
    );
        longint q;
        longint t;
        longint t2;
        longint acc;
        longint s;
        int     i;
        q = longint'(p[29:14]);
        if (p[30]) begin
            q = longint'(65536) - q;
        end
        t   = q <<< 14;
        t2  = (t * t) / Q30;
        acc = POLY_C[4];
        for (i = 3; i >= 0; i--) begin
            acc = POLY_C[i] + (acc * t2) / Q30;
        end
        s = (acc * t) / Q30;
        if (s < 0) begin
            s = 0;
        end
        s = (s + longint'(16384)) >>> 15;
        if (s > longint'(32767)) begin
            s = 32767;
        end
        if (p[31]) begin
            s = -s;
        end
        return s[SINE_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/stereo_ring_modulator.sv
// Stereo ring modulator top level: sine ROM, gain stages and a bit-serial
// sample multiplier. Depends on srm_pkg and stereo_ring_modulator_macros.svh.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  s_      | in  | s_valid / s_ready    | s_left_sample, s_right_sample
//  m_      | out | m_valid / m_ready    | m_left_out, m_right_out
//  cfg_    | in  | cfg_wr_en (no stall) | cfg_index, cfg_data
//
//  Sequence: a transaction is accepted only in IDLE; it then passes through
//    READ, DEPTH, WET, MUL and DONE, and its result is loaded into the output
//    register from DONE. The next transaction is accepted only once the block
//    is back in IDLE. The serial multiplier takes one sample bit per cycle.
//  Reset: phase clears to zero, config registers go to their reset values,
//    output valid drops. The sine ROM is constant, so there is no fill pass.
//  Stalls: the result sits in the output register; a new transaction is taken
//    while it waits, and only the final load stage holds if it is still full.
`include "stereo_ring_modulator_macros.svh"

module stereo_ring_modulator #(
    parameter int SampleWidth = srm_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int TableDepth  = srm_pkg::SINE_DEPTH_DEFAULT
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // input transaction
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [SampleWidth-1:0]              s_left_sample,
    input  logic signed [SampleWidth-1:0]              s_right_sample,
    // result transaction
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [SampleWidth-1:0]              m_left_out,
    output logic signed [SampleWidth-1:0]              m_right_out,
    // config writes
    input  logic                                       cfg_wr_en,
    input  logic [srm_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [srm_pkg::CFG_DATA_WIDTH-1:0]         cfg_data
);

    localparam int IdxW  = $clog2(TableDepth);
    localparam int CntW  = $clog2(SampleWidth);
    localparam int AccW  = srm_pkg::ACC_WIDTH;
    localparam int FullW = SampleWidth + AccW;
    localparam int IdxProdW = srm_pkg::PHASE_WIDTH + IdxW + 1;
    localparam logic [IdxW:0]     DepthConst = (IdxW + 1)'(TableDepth);
    localparam logic [CntW-1:0]   LastBit    = CntW'(SampleWidth - 1);

    // ------------------------------------------------------------------
    // Sine ROM: constant contents, registered read
    // ------------------------------------------------------------------
    logic signed [srm_pkg::SINE_WIDTH-1:0] rom_const [TableDepth];

    for (genvar k = 0; k < TableDepth; k++) begin : g_rom
        localparam logic [31:0] EntryPhase = 32'((64'(k) << 32) / TableDepth);
        assign rom_const[k] = srm_pkg::sine_of_phase(EntryPhase);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    srm_pkg::srm_state_t state_reg, state_next;

    logic [srm_pkg::PHASE_WIDTH-1:0] phase_reg;
    logic [srm_pkg::INC_WIDTH-1:0]   phase_inc_reg;
    logic [srm_pkg::GAIN_WIDTH-1:0]  depth_reg;
    logic [srm_pkg::GAIN_WIDTH-1:0]  mix_reg;
    logic                            m_valid_reg;
    logic [CntW-1:0]                 bit_cnt_reg;

    logic [IdxW-1:0]                       idx_reg;
    logic signed [srm_pkg::SINE_WIDTH-1:0] sine_reg;
    logic signed [srm_pkg::SINE_WIDTH-1:0] m_reg;
    logic signed [srm_pkg::WET_WIDTH-1:0]  w_reg;
    logic [SampleWidth-1:0]                dry_reg [2];
    logic signed [AccW-1:0]                hi_reg  [2];
    logic [SampleWidth-1:0]                lo_reg  [2];
    logic signed [SampleWidth-1:0]         out_reg [2];

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic accept;
    logic out_free;
    logic load_out;
    logic last_bit;

    assign s_ready  = (state_reg == srm_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == srm_pkg::ST_DONE) && out_free;
    assign last_bit = (bit_cnt_reg == LastBit);

    assign m_valid     = m_valid_reg;
    assign m_left_out  = out_reg[0];
    assign m_right_out = out_reg[1];

    // ------------------------------------------------------------------
    // Datapath combinational terms
    // ------------------------------------------------------------------
    // table index = (phase * depth) >> 32
    logic [IdxProdW-1:0] idx_prod;
    logic [IdxW-1:0]     idx_next;
    assign idx_prod = IdxProdW'(phase_reg) * IdxProdW'(DepthConst);
    assign idx_next = idx_prod[IdxW+31:32];

    logic [srm_pkg::PHASE_WIDTH-1:0] phase_next;
    assign phase_next = phase_reg + {1'b0, phase_inc_reg};

    // gains above unity act as unity
    logic [srm_pkg::GAIN_WIDTH-1:0] depth_eff;
    logic [srm_pkg::GAIN_WIDTH-1:0] mix_eff;
    assign depth_eff = (depth_reg > srm_pkg::UNITY) ? srm_pkg::UNITY : depth_reg;
    assign mix_eff   = (mix_reg > srm_pkg::UNITY) ? srm_pkg::UNITY : mix_reg;

    // scaled sine, rounded half up back to Q1.15
    logic signed [32:0]                    sd_prod;
    logic signed [32:0]                    sd_round;
    logic signed [srm_pkg::SINE_WIDTH-1:0] m_next;
    assign sd_prod  = sine_reg * $signed({1'b0, depth_eff});
    assign sd_round = (sd_prod + 33'sd16384) >>> 15;
    assign m_next   = sd_round[srm_pkg::SINE_WIDTH-1:0];

    // per-sample gain: (1-mix)*2^30 + m*mix, shared by both channels
    logic [16:0]                          dry_share;
    logic [srm_pkg::WET_WIDTH-1:0]        dry_gain;
    logic signed [32:0]                   mm_prod;
    logic signed [32:0]                   w_sum;
    logic signed [srm_pkg::WET_WIDTH-1:0] w_next;
    assign dry_share = 17'(srm_pkg::UNITY) - {1'b0, mix_eff};
    assign dry_gain  = {dry_share, 15'd0};
    assign mm_prod   = m_reg * $signed({1'b0, mix_eff});
    assign w_sum     = $signed({1'b0, dry_gain}) + mm_prod;
    assign w_next    = w_sum[srm_pkg::WET_WIDTH-1:0];

    // serial multiply step: LSB first, sign bit of the sample subtracts
    logic signed [AccW-1:0] w_ext;
    logic signed [AccW-1:0] w_neg;
    logic signed [AccW-1:0] step_sum [2];
    logic signed [AccW-1:0] hi_next  [2];
    logic [SampleWidth-1:0] lo_next  [2];
    logic [FullW-1:0]       full_prod [2];
    logic [SampleWidth+2:0] rounded   [2];
    logic signed [SampleWidth-1:0] out_next [2];

    assign w_ext = {w_reg[srm_pkg::WET_WIDTH-1], w_reg};
    assign w_neg = -w_ext;

    function automatic logic signed [SampleWidth-1:0] saturate(
        input logic [SampleWidth+2:0] r
    );
        if (r[SampleWidth+2:SampleWidth-1] == '0 || r[SampleWidth+2:SampleWidth-1] == '1) begin
            return r[SampleWidth-1:0];
        end else if (r[SampleWidth+2]) begin
            return {1'b1, {(SampleWidth-1){1'b0}}};
        end else begin
            return {1'b0, {(SampleWidth-1){1'b1}}};
        end
    endfunction

    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            if (!dry_reg[ch][0]) begin
                step_sum[ch] = hi_reg[ch];
            end else if (last_bit) begin
                step_sum[ch] = hi_reg[ch] + w_neg;
            end else begin
                step_sum[ch] = hi_reg[ch] + w_ext;
            end
            hi_next[ch]   = step_sum[ch] >>> 1;
            lo_next[ch]   = {step_sum[ch][0], lo_reg[ch][SampleWidth-1:1]};
            full_prod[ch] = {hi_reg[ch], lo_reg[ch]};
            rounded[ch]   = full_prod[ch][FullW-1:srm_pkg::ROUND_SHIFT];
            out_next[ch]  = saturate(rounded[ch]);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = srm_pkg::ST_READ;
                end
            end
            srm_pkg::ST_READ:  state_next = srm_pkg::ST_DEPTH;
            srm_pkg::ST_DEPTH: state_next = srm_pkg::ST_WET;
            srm_pkg::ST_WET:   state_next = srm_pkg::ST_MUL;
            srm_pkg::ST_MUL: begin
                if (last_bit) begin
                    state_next = srm_pkg::ST_DONE;
                end
            end
            srm_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = srm_pkg::ST_IDLE;
                end
            end
            default: state_next = srm_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers: config, phase, output valid, bit counter
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            phase_inc_reg <= srm_pkg::PHASE_INC_RESET;
            depth_reg     <= srm_pkg::DEPTH_RESET;
            mix_reg       <= srm_pkg::MIX_RESET;
            m_valid_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    srm_pkg::CFG_PHASE_INC: phase_inc_reg <= cfg_data;
                    srm_pkg::CFG_DEPTH:     depth_reg <= cfg_data[srm_pkg::GAIN_WIDTH-1:0];
                    srm_pkg::CFG_MIX:       mix_reg   <= cfg_data[srm_pkg::GAIN_WIDTH-1:0];
                    default: ;
                endcase
            end
            // phase moves on once per transaction, after its table read
            if (state_reg == srm_pkg::ST_READ) begin
                phase_reg <= phase_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == srm_pkg::ST_WET) begin
                bit_cnt_reg <= '0;
            end else if (state_reg == srm_pkg::ST_MUL) begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg    <= idx_next;
            dry_reg[0] <= s_left_sample;
            dry_reg[1] <= s_right_sample;
        end
        if (state_reg == srm_pkg::ST_READ) begin
            sine_reg <= rom_const[idx_reg];
        end
        if (state_reg == srm_pkg::ST_DEPTH) begin
            m_reg <= m_next;
        end
        if (state_reg == srm_pkg::ST_WET) begin
            w_reg     <= w_next;
            hi_reg[0] <= srm_pkg::ACC_ROUND;
            hi_reg[1] <= srm_pkg::ACC_ROUND;
        end
        if (state_reg == srm_pkg::ST_MUL) begin
            for (int ch = 0; ch < 2; ch++) begin
                hi_reg[ch]  <= hi_next[ch];
                lo_reg[ch]  <= lo_next[ch];
                dry_reg[ch] <= {1'b0, dry_reg[ch][SampleWidth-1:1]};
            end
        end
        if (load_out) begin
            out_reg[0] <= out_next[0];
            out_reg[1] <= out_next[1];
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SRM_ASSERT_NEXT(a_accept_starts_read, aclk, aresetn, accept, state_reg == srm_pkg::ST_READ)
    `SRM_ASSERT_IMPL(a_valid_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == srm_pkg::ST_DONE))
    `SRM_ASSERT_NEXT(a_phase_moves_once, aclk, aresetn, state_reg != srm_pkg::ST_READ, $stable(phase_reg))
    `SRM_ASSERT_IMPL(a_scaled_sine_bound, aclk, aresetn, state_reg == srm_pkg::ST_WET, m_reg != srm_pkg::SINE_MOST_NEG)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for stereo_ring_modulator: directed and random stereo
// transactions against an in-bench sine/crossfade predictor. Depends on srm_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int SW         = srm_pkg::SAMPLE_WIDTH_DEFAULT;
    localparam int ROM_DEPTH  = srm_pkg::SINE_DEPTH_DEFAULT;
    localparam int ROM_BITS   = $clog2(ROM_DEPTH);
    localparam int PH_W       = srm_pkg::PHASE_WIDTH;
    localparam int INC_W      = srm_pkg::INC_WIDTH;
    localparam int GAIN_W     = srm_pkg::GAIN_WIDTH;
    localparam int SINE_W     = srm_pkg::SINE_WIDTH;
    localparam int CFG_IW     = srm_pkg::CFG_INDEX_WIDTH;
    localparam int CFG_DW     = srm_pkg::CFG_DATA_WIDTH;
    localparam int WATCHDOG_LIMIT = 4000;  // longer than the long receiver hold-off, HOLD_CYCLES
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_AT_RESULT = 300;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 110;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    // the one index the decoder leaves unused
    localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

    localparam longint ONE_Q30 = longint'(1) <<< 30;
    localparam longint SIN_COEF [5] = '{
        1686629713, -693598669, 85569306, -5026995, 172272
    };

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } stereo_t;

    typedef enum logic [1:0] {
        RX_OPEN,      // always ready
        RX_COIN,      // ready half the time
        RX_SPARSE,    // ready with a chance of one in five
        RX_PERIODIC   // fixed duty pattern
    } rx_mode_t;

    // ---------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero
    // ---------------------------------------------------------------
    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [SW-1:0]        s_left_sample = '0;
    logic signed [SW-1:0]        s_right_sample = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [SW-1:0]        m_left_out;
    logic signed [SW-1:0]        m_right_out;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0]           cfg_index = srm_pkg::CFG_PHASE_INC;
    logic [CFG_DW-1:0]           cfg_data = '0;

    stereo_ring_modulator DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: sine ROM image, register copies, phase
    // ---------------------------------------------------------------
    logic signed [SINE_W-1:0] sine_rom [ROM_DEPTH];
    logic [INC_W-1:0]         inc_cfg;
    logic [GAIN_W-1:0]        depth_cfg;
    logic [GAIN_W-1:0]        mix_cfg;
    logic [PH_W-1:0]          phase_acc;

    stereo_t pending_q [$];    // stimulus not yet offered
    stereo_t expected_q [$];   // predicted results, oldest first

    int  items_queued   = 0;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  idle_cycles    = 0;
    bit  in_taken       = 1'b0;  // set at the edge an input transaction completes

    // Quarter-wave odd polynomial in Q2.30, folded to the full circle,
    // rounded half up to Q1.15 and held to +-32767.
    function automatic logic signed [SINE_W-1:0] sine_q15(logic [PH_W-1:0] ph);
        longint q;
        longint t;
        longint t2;
        longint acc;
        longint s;
        int     i;
        q = longint'(ph[29:14]);
        if (ph[30]) begin
            q = 65536 - q;
        end
        t   = q <<< 14;
        t2  = (t * t) / ONE_Q30;
        acc = SIN_COEF[4];
        for (i = 3; i >= 0; i--) begin
            acc = SIN_COEF[i] + (acc * t2) / ONE_Q30;
        end
        s = (acc * t) / ONE_Q30;
        if (s < 0) begin
            s = 0;
        end
        s = (s + 16384) >>> 15;
        if (s > 32767) begin
            s = 32767;
        end
        if (ph[31]) begin
            s = -s;
        end
        return s[SINE_W-1:0];
    endfunction

    // dry*(1-mix) + dry*m*mix at the 2^30 scale, rounded half up, saturated
    function automatic logic signed [SW-1:0] crossfade(longint dry, longint m, longint mix);
        longint acc;
        longint r;
        longint hi;
        hi  = (longint'(1) <<< (SW - 1)) - 1;
        acc = dry * (32768 - mix) * 32768 + dry * m * mix;
        r   = (acc + (longint'(1) <<< 29)) >>> 30;
        if (r > hi) begin
            r = hi;
        end
        if (r < -hi - 1) begin
            r = -hi - 1;
        end
        return r[SW-1:0];
    endfunction

    // One stereo transaction in, one out; advances the phase afterwards.
    function automatic stereo_t ring_mod_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
        stereo_t res;
        longint  s;
        longint  depth;
        longint  mix;
        longint  m;
        s     = longint'(sine_rom[phase_acc[PH_W-1 -: ROM_BITS]]);
        depth = (depth_cfg > srm_pkg::UNITY) ? longint'(srm_pkg::UNITY)
                                             : longint'(depth_cfg);
        mix   = (mix_cfg > srm_pkg::UNITY) ? longint'(srm_pkg::UNITY) : longint'(mix_cfg);
        m     = (s * depth + 16384) >>> 15;
        res.left  = crossfade(longint'(l), m, mix);
        res.right = crossfade(longint'(r), m, mix);
        phase_acc = phase_acc + PH_W'(inc_cfg);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of random length, random gaps; changes at negedge
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge aclk) begin
        stereo_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold payload until the transaction completes
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (pending_q.size() > 0) begin
            nxt = pending_q.pop_front();
            s_valid        <= 1'b1;
            s_left_sample  <= nxt.left;
            s_right_sample <= nxt.right;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 48);
                // mostly short gaps, sometimes longer than a whole item
                gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                       : $urandom_range(0, 3);
            end else begin
                burst_left--;
            end
        end else begin
            s_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // ---------------------------------------------------------------
    // Receiver: own stall pattern plus one long hold-off so the output
    // register fills and the input side backs up
    // ---------------------------------------------------------------
    rx_mode_t rx_mode   = RX_OPEN;
    int       rx_cycle  = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        end
        if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                RX_OPEN:     m_ready <= 1'b1;
                RX_COIN:     m_ready <= $urandom_range(0, 1);
                RX_SPARSE:   m_ready <= ($urandom_range(0, 4) == 0);
                RX_PERIODIC: m_ready <= ((rx_cycle % 7) < 3);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on each input transaction, checks each result
    // transaction against the oldest prediction; watchdog on stalls
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        bit      in_fire;
        bit      out_fire;
        stereo_t want;
        in_fire  = aresetn && s_valid && s_ready;
        out_fire = aresetn && m_valid && m_ready;
        if (in_fire) begin
            expected_q.push_back(ring_mod_pair(s_left_sample, s_right_sample));
            items_accepted++;
            in_taken = 1'b1;
        end
        if (out_fire) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: L=%0d R=%0d", m_left_out, m_right_out);
                end
            end else begin
                want = expected_q.pop_front();
                if (want.left !== m_left_out || want.right !== m_right_out) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at result %0d: expected L=%0d R=%0d, got L=%0d R=%0d",
                                 results_seen, want.left, want.right, m_left_out, m_right_out);
                    end
                end
            end
        end
        if (in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
        stereo_t item;
        item.left  = l;
        item.right = r;
        pending_q.push_back(item);
        items_queued++;
    endtask

    // Register write at negedge; the block is idle, so the predictor's
    // copy takes the new value at once.
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            srm_pkg::CFG_PHASE_INC: inc_cfg   = data[INC_W-1:0];
            srm_pkg::CFG_DEPTH:     depth_cfg = data[GAIN_W-1:0];
            srm_pkg::CFG_MIX:       mix_cfg   = data[GAIN_W-1:0];
            default:                ;  // unused index: no effect
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Wait until every transaction is in and every result out, then let the
    // sequencer settle before touching config.
    task automatic wait_drained();
        while (items_accepted != items_queued || results_seen != items_accepted) begin
            @(negedge aclk);
        end
        repeat (SW + 8) @(negedge aclk);
    endtask

    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SW'($urandom_range(0, 511) - 256);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain(int unsigned floor_val);
        case ($urandom_range(0, 7))
            0:       return GAIN_W'(floor_val);
            1:       return srm_pkg::UNITY;
            2:       return GAIN_W'($urandom_range(0, floor_val));   // below range
            3:       return GAIN_W'($urandom_range(32769, 65535));   // above range
            default: return GAIN_W'($urandom_range(floor_val, 32768));
        endcase
    endfunction

    function automatic logic [INC_W-1:0] random_increment();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {INC_W{1'b1}};
            2:       return INC_W'($urandom_range(1, 2000000));
            default: return INC_W'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int k;
        int ph;
        int n;
        for (k = 0; k < ROM_DEPTH; k++) begin
            sine_rom[k] = sine_q15(PH_W'((longint'(k) <<< 32) / ROM_DEPTH));
        end
        phase_acc = '0;
        inc_cfg   = srm_pkg::PHASE_INC_RESET;
        depth_cfg = srm_pkg::DEPTH_RESET;
        mix_cfg   = srm_pkg::MIX_RESET;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: dry only, phase starts at zero
        push_pair(SAMPLE_MAX, SAMPLE_MAX);
        push_pair(SAMPLE_MIN, SAMPLE_MIN);
        push_pair('0, '0);
        push_pair(SAMPLE_MAX, SAMPLE_MIN);
        push_pair(-1, 1);
        wait_drained();

        // full wet, unity depth, quarter-turn steps: lands near 0, peak, 0, trough
        write_reg(srm_pkg::CFG_MIX, CFG_DW'(srm_pkg::UNITY));
        write_reg(srm_pkg::CFG_DEPTH, CFG_DW'(srm_pkg::UNITY));
        write_reg(srm_pkg::CFG_PHASE_INC, CFG_DW'(1) << 30);
        for (k = 0; k < 4; k++) begin
            push_pair(SAMPLE_MAX, SAMPLE_MIN);
            push_pair(SAMPLE_MIN, SAMPLE_MAX);
        end
        wait_drained();

        // depth and mix above range, write to the unused index, largest
        // increment so the accumulator wraps every other transaction
        write_reg(srm_pkg::CFG_DEPTH, {CFG_DW{1'b1}});
        write_reg(srm_pkg::CFG_MIX, {CFG_DW{1'b1}});
        write_reg(CFG_SPARE, CFG_DW'($urandom));
        write_reg(srm_pkg::CFG_PHASE_INC, {CFG_DW{1'b1}});
        for (k = 0; k < 6; k++) begin
            push_pair((k % 2) ? SAMPLE_MIN : SAMPLE_MAX, random_sample());
        end
        wait_drained();

        // depth below range (zero), half mix
        write_reg(srm_pkg::CFG_DEPTH, '0);
        write_reg(srm_pkg::CFG_MIX, CFG_DW'(16384));
        write_reg(srm_pkg::CFG_PHASE_INC, CFG_DW'(12345));
        push_pair(SAMPLE_MAX, SAMPLE_MIN);
        push_pair(SAMPLE_MIN, SAMPLE_MAX);
        push_pair(random_sample(), random_sample());
        push_pair(random_sample(), random_sample());
        wait_drained();

        // random phases, each with a fresh setting; upper data bits are noise
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_reg(srm_pkg::CFG_PHASE_INC, CFG_DW'(random_increment()));
            write_reg(srm_pkg::CFG_DEPTH, {15'($urandom), random_gain(16384)});
            write_reg(srm_pkg::CFG_MIX, {15'($urandom), random_gain(0)});
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_SPARE, CFG_DW'($urandom));
            end
            n = PHASE_ITEMS + $urandom_range(0, 10);
            for (k = 0; k < n; k++) begin
                push_pair(random_sample(), random_sample());
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/srm_pkg.sv
rtl/stereo_ring_modulator.sv
test/tb_top.sv
